[hw/rtl/trap_dispatch_with_branch_probe_unit_assert.svh]
// Assertion macros for the trap dispatch unit.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef TRAP_DISPATCH_WITH_BRANCH_PROBE_UNIT_ASSERT_SVH
`define TRAP_DISPATCH_WITH_BRANCH_PROBE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TDBP_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TDBP_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[hw/rtl/tdbp_pkg.sv]
// Shared constants and types for the trap dispatch unit.
// No dependencies; used by tdbp_resolve and the top level.
package tdbp_pkg;

    // trap causes and recognized trap values
    localparam logic [63:0] CAUSE_ILLEGAL = 64'h2;
    localparam logic [63:0] CAUSE_BREAK   = 64'h3;
    localparam logic [63:0] INSN_MRET     = 64'h3020_0073;
    localparam logic [63:0] INSN_SRET     = 64'h1020_0073;
    localparam logic [63:0] INSN_URET     = 64'h0020_0073;

    // event codes carried in t1
    localparam logic [63:0] EV_CALL       = 64'h1;
    localparam logic [63:0] EV_RETURN     = 64'h2;
    localparam logic [63:0] EV_CALL_IND   = 64'h3;
    localparam logic [63:0] PROBE_CODE    = 64'h80;

    // probed instruction decode
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [1:0] LEN32_TAG = 2'b11;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // action kinds
    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_PROBE = 2'd1;
    localparam logic [1:0] KIND_RET   = 2'd2;
    localparam logic [1:0] KIND_DELEG = 2'd3;

    // configuration port
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_VEC_PC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEC_SP = 2'd1;

    // update of the saved trap context
    typedef struct packed {
        logic save;
        logic clear;
    } state_op_t;

endpackage

[hw/rtl/tdbp_resolve.sv]
// Combinational resolve of one trap beat: dispatch, probe decode, event fields.
// Depends on tdbp_pkg.
module tdbp_resolve #(
    parameter int XLEN = 64
) (
    input  logic [XLEN-1:0]     cause,
    input  logic [XLEN-1:0]     trap_value,
    input  logic [XLEN-1:0]     cur_pc,
    input  logic [XLEN-1:0]     cur_sp,
    input  logic [XLEN-1:0]     block_id,
    input  logic [XLEN-1:0]     event_code,
    input  logic [15:0]         trap_half,
    input  logic [31:0]         probe_word,
    input  logic [XLEN-1:0]     rs1_value,
    input  logic [XLEN-1:0]     rs2_value,
    input  logic [XLEN-1:0]     saved_pc,
    input  logic [XLEN-1:0]     saved_sp,
    input  logic [XLEN-1:0]     vec_pc,
    input  logic [XLEN-1:0]     vec_sp,
    output logic [XLEN-1:0]     next_pc,
    output logic [XLEN-1:0]     next_sp,
    output logic [1:0]          action_kind,
    output logic                event_valid,
    output logic [XLEN-1:0]     event_addr,
    output logic [XLEN-1:0]     event_data,
    output logic [7:0]          event_tag,
    output logic                event_is_call,
    output logic                event_is_return,
    output tdbp_pkg::state_op_t state_op
);
    import tdbp_pkg::*;

    localparam int OFF_W = 22;

    logic                is_break;
    logic                is_xret;
    logic                is_probe;
    logic                is_jalr;
    logic [XLEN-1:0]     after_pc;
    logic [6:0]          opcode;
    logic [2:0]          funct3;
    logic [XLEN-1:0]     v1;
    logic [XLEN-1:0]     v2;
    logic                taken;
    logic [OFF_W-1:0]    len_off;
    logic [OFF_W-1:0]    j_imm;
    logic [OFF_W-1:0]    b_imm;
    logic [OFF_W-1:0]    i_imm;
    logic [OFF_W-1:0]    rel_off;
    logic [OFF_W-1:0]    tgt_off;
    logic [XLEN-1:0]     tgt_base;
    logic [XLEN-1:0]     tgt_sum;
    logic [XLEN-1:0]     target;

    assign is_break = (cause == XLEN'(CAUSE_BREAK));
    assign is_xret  = (cause == XLEN'(CAUSE_ILLEGAL))
                   && ((trap_value == XLEN'(INSN_MRET))
                    || (trap_value == XLEN'(INSN_SRET))
                    || (trap_value == XLEN'(INSN_URET)));
    assign is_probe = (event_code == XLEN'(PROBE_CODE));

    // ebreak length from the low half at pc
    assign len_off  = (trap_half[1:0] == LEN32_TAG) ? OFF_W'(4) : OFF_W'(2);
    assign after_pc = cur_pc + {{(XLEN-OFF_W){len_off[OFF_W-1]}}, len_off};

    assign opcode = probe_word[6:0];
    assign funct3 = probe_word[14:12];
    assign v1 = (probe_word[19:15] != 5'd0) ? rs1_value : '0;
    assign v2 = (probe_word[24:20] != 5'd0) ? rs2_value : '0;

    assign j_imm = {probe_word[31], probe_word[31], probe_word[19:12], probe_word[20],
                    probe_word[30:21], 1'b0};
    assign b_imm = {{9{probe_word[31]}}, probe_word[31], probe_word[7],
                    probe_word[30:25], probe_word[11:8], 1'b0};
    assign i_imm = {{10{probe_word[31]}}, probe_word[31:20]};

    always_comb
    begin
        case (funct3)
            F3_BEQ:  taken = (v1 == v2);
            F3_BNE:  taken = (v1 != v2);
            F3_BLT:  taken = ($signed(v1) < $signed(v2));
            F3_BGE:  taken = !($signed(v1) < $signed(v2));
            F3_BLTU: taken = (v1 < v2);
            F3_BGEU: taken = (v1 >= v2);
            default: taken = 1'b0;
        endcase
    end

    // pc-relative targets fold the ebreak length into a narrow offset,
    // so one wide add off cur_pc covers them; jalr adds to rs1 instead
    always_comb
    begin
        rel_off = OFF_W'(4);
        if (probe_word[1:0] != LEN32_TAG)
        begin
            rel_off = OFF_W'(2);
        end
        else if (opcode == OP_JAL)
        begin
            rel_off = j_imm;
        end
        else if (opcode == OP_BRANCH && taken)
        begin
            rel_off = b_imm;
        end
    end

    assign is_jalr  = (probe_word[1:0] == LEN32_TAG) && (opcode == OP_JALR);
    assign tgt_off  = is_jalr ? i_imm : (len_off + rel_off);
    assign tgt_base = is_jalr ? v1 : cur_pc;
    assign tgt_sum  = tgt_base + {{(XLEN-OFF_W){tgt_off[OFF_W-1]}}, tgt_off};
    assign target   = is_jalr ? {tgt_sum[XLEN-1:1], 1'b0} : tgt_sum;

    always_comb
    begin
        next_pc         = vec_pc;
        next_sp         = vec_sp;
        action_kind     = KIND_DELEG;
        event_valid     = 1'b0;
        event_addr      = '0;
        event_data      = '0;
        event_tag       = '0;
        event_is_call   = 1'b0;
        event_is_return = 1'b0;
        state_op.save   = 1'b0;
        state_op.clear  = 1'b0;
        if (is_break)
        begin
            next_pc     = after_pc;
            next_sp     = cur_sp;
            event_valid = 1'b1;
            if (is_probe)
            begin
                action_kind = KIND_PROBE;
                event_addr  = after_pc;
                event_data  = target;
                event_tag   = PROBE_CODE[7:0];
            end
            else
            begin
                action_kind     = KIND_EVENT;
                event_addr      = cur_pc;
                event_data      = block_id;
                event_tag       = event_code[7:0];
                event_is_call   = (event_code == XLEN'(EV_CALL))
                               || (event_code == XLEN'(EV_CALL_IND));
                event_is_return = (event_code == XLEN'(EV_RETURN));
            end
        end
        else if (is_xret)
        begin
            next_pc        = saved_pc;
            next_sp        = saved_sp;
            action_kind    = KIND_RET;
            state_op.clear = 1'b1;
        end
        else
        begin
            state_op.save = 1'b1;
        end
    end

endmodule

[hw/rtl/trap_dispatch_with_branch_probe_unit.sv]
// Trap dispatch unit: breakpoint events, branch probes, trap return, delegation.
// Depends on tdbp_pkg, tdbp_resolve and the assertion macro header.
//
// Path: each beat passes the input register, then the result register.
// Throughput: one trap per cycle while out_stall is low; the saved-context register
//   updates as a beat leaves stage 1, so back-to-back traps see each other's effect.
// Reset: rst_n asynchronous, active low; clears both pipeline valids, the saved
//   pc/sp and both configuration registers.
module trap_dispatch_with_branch_probe_unit #(
    parameter int XLEN = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [tdbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [XLEN-1:0]                cfg_data,
    // trap input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [XLEN-1:0]                cause,
    input  logic [XLEN-1:0]                trap_value,
    input  logic [XLEN-1:0]                cur_pc,
    input  logic [XLEN-1:0]                cur_sp,
    input  logic [XLEN-1:0]                block_id,
    input  logic [XLEN-1:0]                event_code,
    input  logic [15:0]                    trap_half,
    input  logic [31:0]                    probe_word,
    input  logic [XLEN-1:0]                rs1_value,
    input  logic [XLEN-1:0]                rs2_value,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [XLEN-1:0]                next_pc,
    output logic [XLEN-1:0]                next_sp,
    output logic [1:0]                     action_kind,
    output logic                           event_valid,
    output logic [XLEN-1:0]                event_addr,
    output logic [XLEN-1:0]                event_data,
    output logic [7:0]                     event_tag,
    output logic                           event_is_call,
    output logic                           event_is_return
);
    import tdbp_pkg::*;

`include "trap_dispatch_with_branch_probe_unit_assert.svh"

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [XLEN-1:0] vec_pc_reg;
    logic [XLEN-1:0] vec_sp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_pc_reg <= '0;
            vec_sp_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VEC_PC: vec_pc_reg <= cfg_data;
                CFG_VEC_SP: vec_sp_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // handshake: stage 1 (input register) -> stage 2 (result register)
    // ---------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_ready;    // result register can take a beat this cycle
    logic s1_fire;      // stage 1 beat moves into the result register
    logic in_fire;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_fire   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input register (payload, no reset)
    logic [XLEN-1:0] cause_reg;
    logic [XLEN-1:0] trap_value_reg;
    logic [XLEN-1:0] cur_pc_reg;
    logic [XLEN-1:0] cur_sp_reg;
    logic [XLEN-1:0] block_id_reg;
    logic [XLEN-1:0] event_code_reg;
    logic [15:0]     trap_half_reg;
    logic [31:0]     probe_word_reg;
    logic [XLEN-1:0] rs1_value_reg;
    logic [XLEN-1:0] rs2_value_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cause_reg      <= cause;
            trap_value_reg <= trap_value;
            cur_pc_reg     <= cur_pc;
            cur_sp_reg     <= cur_sp;
            block_id_reg   <= block_id;
            event_code_reg <= event_code;
            trap_half_reg  <= trap_half;
            probe_word_reg <= probe_word;
            rs1_value_reg  <= rs1_value;
            rs2_value_reg  <= rs2_value;
        end
    end

    // ---------------------------------------------------------------
    // saved trap context: written by delegation, cleared by xRET.
    // Only pc and sp are ever read back, so cause and value are not kept.
    // ---------------------------------------------------------------
    logic [XLEN-1:0] saved_pc_reg;
    logic [XLEN-1:0] saved_sp_reg;
    state_op_t       state_op;

    // ---------------------------------------------------------------
    // resolve logic between the two registers
    // ---------------------------------------------------------------
    logic [XLEN-1:0] next_pc_next;
    logic [XLEN-1:0] next_sp_next;
    logic [1:0]      action_kind_next;
    logic            event_valid_next;
    logic [XLEN-1:0] event_addr_next;
    logic [XLEN-1:0] event_data_next;
    logic [7:0]      event_tag_next;
    logic            event_is_call_next;
    logic            event_is_return_next;

    tdbp_resolve #(
        .XLEN (XLEN)
    ) u_resolve (
        .cause           (cause_reg),
        .trap_value      (trap_value_reg),
        .cur_pc          (cur_pc_reg),
        .cur_sp          (cur_sp_reg),
        .block_id        (block_id_reg),
        .event_code      (event_code_reg),
        .trap_half       (trap_half_reg),
        .probe_word      (probe_word_reg),
        .rs1_value       (rs1_value_reg),
        .rs2_value       (rs2_value_reg),
        .saved_pc        (saved_pc_reg),
        .saved_sp        (saved_sp_reg),
        .vec_pc          (vec_pc_reg),
        .vec_sp          (vec_sp_reg),
        .next_pc         (next_pc_next),
        .next_sp         (next_sp_next),
        .action_kind     (action_kind_next),
        .event_valid     (event_valid_next),
        .event_addr      (event_addr_next),
        .event_data      (event_data_next),
        .event_tag       (event_tag_next),
        .event_is_call   (event_is_call_next),
        .event_is_return (event_is_return_next),
        .state_op        (state_op)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saved_pc_reg <= '0;
            saved_sp_reg <= '0;
        end
        else if (s1_fire)
        begin
            if (state_op.save)
            begin
                saved_pc_reg <= cur_pc_reg;
                saved_sp_reg <= cur_sp_reg;
            end
            else if (state_op.clear)
            begin
                saved_pc_reg <= '0;
                saved_sp_reg <= '0;
            end
        end
    end

    // result register (payload, no reset)
    logic [XLEN-1:0] next_pc_reg;
    logic [XLEN-1:0] next_sp_reg;
    logic [1:0]      action_kind_reg;
    logic            event_valid_reg;
    logic [XLEN-1:0] event_addr_reg;
    logic [XLEN-1:0] event_data_reg;
    logic [7:0]      event_tag_reg;
    logic            event_is_call_reg;
    logic            event_is_return_reg;

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            next_pc_reg         <= next_pc_next;
            next_sp_reg         <= next_sp_next;
            action_kind_reg     <= action_kind_next;
            event_valid_reg     <= event_valid_next;
            event_addr_reg      <= event_addr_next;
            event_data_reg      <= event_data_next;
            event_tag_reg       <= event_tag_next;
            event_is_call_reg   <= event_is_call_next;
            event_is_return_reg <= event_is_return_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign next_pc         = next_pc_reg;
    assign next_sp         = next_sp_reg;
    assign action_kind     = action_kind_reg;
    assign event_valid     = event_valid_reg;
    assign event_addr      = event_addr_reg;
    assign event_data      = event_data_reg;
    assign event_tag       = event_tag_reg;
    assign event_is_call   = event_is_call_reg;
    assign event_is_return = event_is_return_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `TDBP_ASSERT_IMPLY(a_no_event_on_ret_deleg, clk, rst_n,
        out_valid_reg && (action_kind_reg == KIND_RET || action_kind_reg == KIND_DELEG),
        !event_valid_reg && !event_is_call_reg && !event_is_return_reg,
        "event fields set on a return or delegated beat")
    `TDBP_ASSERT_IMPLY(a_probe_fields, clk, rst_n,
        out_valid_reg && action_kind_reg == KIND_PROBE,
        event_valid_reg && event_tag_reg == PROBE_CODE[7:0] && !event_is_call_reg
            && !event_is_return_reg,
        "probe beat with wrong event fields")
    `TDBP_ASSERT_NEXT(a_ret_clears_ctx, clk, rst_n,
        s1_fire && state_op.clear,
        saved_pc_reg == '0 && saved_sp_reg == '0,
        "saved context not cleared after trap return")
    `TDBP_ASSERT_IMPLY(a_stall_only_when_full, clk, rst_n,
        in_stall,
        s1_valid_reg && out_valid_reg,
        "input stalled with room in the pipeline")

endmodule
